// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the GHASH accumulator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("%m: next-cycle check failed");

`endif

// ===== src/ghacc_pkg.sv =====
// ----------------------------------------------------------------------------
// ghacc_pkg
// Types, constants and GF(2^128) helpers for the GHASH accumulator.
// ----------------------------------------------------------------------------
package ghacc_pkg;

    localparam int HALF_W      = 64;
    localparam int BLOCK_W     = 128;
    localparam int BLOCK_BYTES = 16;
    localparam int COUNT_W     = 5;
    localparam int CFG_INDEX_W = 1;
    localparam int QUEUE_DEPTH = 2;

    // GCM reduction constant, as it sits in byte 0 of the reflected polynomial
    localparam logic [7:0] GCM_RED = 8'hE1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SUBKEY_HIGH = 1'b0,
        REG_SUBKEY_LOW  = 1'b1
    } cfg_reg_t;

    // One queued transaction: already masked and classified
    typedef struct packed {
        logic               start;
        logic               absorb;
        logic [BLOCK_W-1:0] block;
    } ghacc_entry_t;

    localparam int ENTRY_W = $bits(ghacc_entry_t);

    function automatic logic [BLOCK_W-1:0] bit_reverse(input logic [BLOCK_W-1:0] v);
        logic [BLOCK_W-1:0] r;
        for (int i = 0; i < BLOCK_W; i++)
        begin
            r[i] = v[BLOCK_W-1-i];
        end
        return r;
    endfunction

    // Zero every byte at or past the valid count; counts above 16 keep all bytes
    function automatic logic [BLOCK_W-1:0] mask_block(input logic [BLOCK_W-1:0] blk,
                                                      input logic [COUNT_W-1:0] count);
        logic [BLOCK_W-1:0] r;
        for (int j = 0; j < BLOCK_BYTES; j++)
        begin
            r[BLOCK_W-1-8*j -: 8] = (COUNT_W'(j) < count) ? blk[BLOCK_W-1-8*j -: 8] : 8'h00;
        end
        return r;
    endfunction

    // X * H in GF(2^128), GCM bit order: MSB of the word is the x^0 coefficient.
    // Carry-less product in natural order, then two folds by x^128 = 1+x+x^2+x^7.
    function automatic logic [BLOCK_W-1:0] gf128_mul(input logic [BLOCK_W-1:0] x,
                                                     input logic [BLOCK_W-1:0] h);
        logic [BLOCK_W-1:0]   a;
        logic [BLOCK_W-1:0]   b;
        logic [2*BLOCK_W-2:0] p;
        logic [BLOCK_W-2:0]   hi;
        logic [BLOCK_W+5:0]   t;
        logic [5:0]           g;
        logic [BLOCK_W-1:0]   r;
        a = bit_reverse(x);
        b = bit_reverse(h);
        p = '0;
        for (int i = 0; i < BLOCK_W; i++)
        begin
            if (a[i])
            begin
                p = p ^ ({(BLOCK_W-1)'(0), b} << i);
            end
        end
        hi = p[2*BLOCK_W-2:BLOCK_W];
        t  = '0;
        for (int k = 0; k < 8; k++)
        begin
            if (GCM_RED[7-k])
            begin
                t = t ^ ({7'b0, hi} << k);
            end
        end
        g = t[BLOCK_W+5:BLOCK_W];
        r = p[BLOCK_W-1:0] ^ t[BLOCK_W-1:0];
        for (int k = 0; k < 8; k++)
        begin
            if (GCM_RED[7-k])
            begin
                r = r ^ ({(BLOCK_W-6)'(0), g} << k);
            end
        end
        return bit_reverse(r);
    endfunction

endpackage

// ===== src/ghacc_front.sv =====
// ----------------------------------------------------------------------------
// ghacc_front
// Input side: accepts transactions, masks the block, classifies, pushes queue.
// ----------------------------------------------------------------------------
module ghacc_front
(
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                start_req,
    input  logic [ghacc_pkg::HALF_W-1:0]        block_high,
    input  logic [ghacc_pkg::HALF_W-1:0]        block_low,
    input  logic [ghacc_pkg::COUNT_W-1:0]       byte_count,
    input  logic                                queue_full,
    output logic                                push,
    output ghacc_pkg::ghacc_entry_t             entry
);

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        entry.start  = start_req;
        // zero count: nothing absorbed, no multiply
        entry.absorb = (byte_count != '0);
        entry.block  = ghacc_pkg::mask_block({block_high, block_low}, byte_count);
    end

endmodule

// ===== src/ghacc_fifo.sv =====
// ----------------------------------------------------------------------------
// ghacc_fifo
// Short queue between the front and the back, registered storage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ghacc_fifo
#(
    parameter int WIDTH = ghacc_pkg::ENTRY_W,
    parameter int DEPTH = ghacc_pkg::QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic             rd_valid,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH))
    `ASSERT_NEXT(a_push_grows, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

// ===== src/ghacc_back.sv =====
// ----------------------------------------------------------------------------
// ghacc_back
// Execution side: absorbs queued blocks into the accumulator, multiplies by H.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ghacc_back
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [ghacc_pkg::BLOCK_W-1:0]       subkey,
    input  logic                                q_valid,
    input  ghacc_pkg::ghacc_entry_t             q_data,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [ghacc_pkg::HALF_W-1:0]        hash_high,
    output logic [ghacc_pkg::HALF_W-1:0]        hash_low
);

    // accumulator doubles as the output register: it only moves on pop
    logic [ghacc_pkg::BLOCK_W-1:0] acc_reg;
    logic [ghacc_pkg::BLOCK_W-1:0] acc_next;
    logic [ghacc_pkg::BLOCK_W-1:0] base;
    logic                          out_valid_reg;
    logic                          out_valid_next;

    assign pop = q_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        base     = q_data.start ? '0 : acc_reg;
        acc_next = acc_reg;
        if (pop)
        begin
            acc_next = q_data.absorb ? ghacc_pkg::gf128_mul(base ^ q_data.block, subkey)
                                     : base;
        end
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign hash_high = acc_reg[ghacc_pkg::BLOCK_W-1:ghacc_pkg::HALF_W];
    assign hash_low  = acc_reg[ghacc_pkg::HALF_W-1:0];

    `ASSERT_NEXT(a_empty_keeps, clk, rst_n, pop && !q_data.start && !q_data.absorb, acc_reg == $past(acc_reg))
    `ASSERT_NEXT(a_start_clears, clk, rst_n, pop && q_data.start && !q_data.absorb, acc_reg == '0)

endmodule

// ===== src/ghash_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// ghash_accumulator_core
// GCM GHASH accumulator: masked block XOR accumulator, times H in GF(2^128).
// ----------------------------------------------------------------------------
//   channel   handshake            payload
//   input     in_valid / in_stall  start_req, block_high, block_low, byte_count
//   output    out_valid/out_stall  hash_high, hash_low
//   config    cfg_wr_en            cfg_index, cfg_data
//
// Throughput is one block per cycle while out_stall is low, with the GF(2^128)
// multiply done combinationally in the accumulator feedback loop of the back end.
// A transaction is registered in the queue, then in the accumulator, which holds the result.
// in_stall rises only when the queue holds QUEUE_DEPTH transactions.
// Reset clears the subkey, the accumulator and all handshake state.
// ----------------------------------------------------------------------------
module ghash_accumulator_core
#(
    parameter int QUEUE_DEPTH = ghacc_pkg::QUEUE_DEPTH
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [ghacc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ghacc_pkg::HALF_W-1:0]        cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                start_req,
    input  logic [ghacc_pkg::HALF_W-1:0]        block_high,
    input  logic [ghacc_pkg::HALF_W-1:0]        block_low,
    input  logic [ghacc_pkg::COUNT_W-1:0]       byte_count,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [ghacc_pkg::HALF_W-1:0]        hash_high,
    output logic [ghacc_pkg::HALF_W-1:0]        hash_low
);

    logic [ghacc_pkg::HALF_W-1:0]  subkey_high_reg;
    logic [ghacc_pkg::HALF_W-1:0]  subkey_high_next;
    logic [ghacc_pkg::HALF_W-1:0]  subkey_low_reg;
    logic [ghacc_pkg::HALF_W-1:0]  subkey_low_next;
    logic                          push;
    logic                          queue_full;
    logic                          q_valid;
    logic                          pop;
    ghacc_pkg::ghacc_entry_t       wr_entry;
    logic [ghacc_pkg::ENTRY_W-1:0] q_rd_data;

    always_comb
    begin
        subkey_high_next = subkey_high_reg;
        subkey_low_next  = subkey_low_reg;
        if (cfg_wr_en)
        begin
            case (ghacc_pkg::cfg_reg_t'(cfg_index))
                ghacc_pkg::REG_SUBKEY_HIGH: subkey_high_next = cfg_data;
                ghacc_pkg::REG_SUBKEY_LOW:  subkey_low_next  = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            subkey_high_reg <= '0;
            subkey_low_reg  <= '0;
        end
        else
        begin
            subkey_high_reg <= subkey_high_next;
            subkey_low_reg  <= subkey_low_next;
        end
    end

    ghacc_front u_front
    (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .start_req  (start_req),
        .block_high (block_high),
        .block_low  (block_low),
        .byte_count (byte_count),
        .queue_full (queue_full),
        .push       (push),
        .entry      (wr_entry)
    );

    ghacc_fifo
    #(
        .WIDTH (ghacc_pkg::ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_data  (wr_entry),
        .full     (queue_full),
        .pop      (pop),
        .rd_valid (q_valid),
        .rd_data  (q_rd_data)
    );

    ghacc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .subkey    ({subkey_high_reg, subkey_low_reg}),
        .q_valid   (q_valid),
        .q_data    (ghacc_pkg::ghacc_entry_t'(q_rd_data)),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .hash_high (hash_high),
        .hash_low  (hash_low)
    );

endmodule
